/* hdl/rlfb_pkg.sv */
// Shared types, constants and table functions for the reactive LED fader.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package rlfb_pkg;

  localparam int LED_COUNT = 9;
  localparam int LED_W     = 4;
  localparam int LEVEL_W   = 8;
  localparam int IDLE_W    = 11;
  localparam int PHASE_W   = 16;
  localparam int FRAME_W   = 32;
  localparam int CFG_W     = 16;
  localparam int BTN_W     = 9;
  localparam int WAVE_W    = 17;

  localparam logic [LED_W-1:0]   LED_LAST = LED_W'(LED_COUNT - 1);
  localparam logic [IDLE_W-1:0]  IDLE_MAX = '1;

  // register defaults
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET    = 8'd255;
  localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RESET   = 11'd1000;
  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET   = 16'd209;
  localparam logic [PHASE_W-1:0] PHASE_SPREAD_RESET = 16'd6258;
  localparam logic [IDLE_W-1:0]  IDLE_COUNT_RESET   = 11'd1001;

  typedef enum logic [1:0] {
    REG_MAX_LEVEL    = 2'd0,
    REG_IDLE_LIMIT   = 2'd1,
    REG_PHASE_STEP   = 2'd2,
    REG_PHASE_SPREAD = 2'd3
  } cfg_reg_t;

  // microprogram steps, in program order
  typedef enum logic [2:0] {
    STEP_WAIT  = 3'd0,
    STEP_BASE  = 3'd1,
    STEP_PHASE = 3'd2,
    STEP_ROM   = 3'd3,
    STEP_WAVE  = 3'd4,
    STEP_PIX   = 3'd5,
    STEP_OUT   = 3'd6,
    STEP_NEXT  = 3'd7
  } step_t;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_NO_TICK  = 2'd1,
    COND_OUT_BUSY = 2'd2,
    COND_MORE     = 2'd3
  } cond_t;

  typedef struct packed {
    logic  tick_ready;
    logic  base_load;
    logic  phase_load;
    logic  rom_load;
    logic  wave_load;
    logic  pix_load;
    logic  out_load;
    logic  led_adv;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic tick_valid;
    logic out_busy;
    logic led_last;
  } stat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
  } rgb_t;

  // control store
  function automatic ctrl_t program_word(step_t s);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_NONE;
    w.target = STEP_WAIT;
    unique case (s)
      STEP_WAIT: begin
        w.tick_ready = 1'b1;
        w.cond       = COND_NO_TICK;
        w.target     = STEP_WAIT;
      end
      STEP_BASE:  w.base_load  = 1'b1;
      STEP_PHASE: w.phase_load = 1'b1;
      STEP_ROM:   w.rom_load   = 1'b1;
      STEP_WAVE:  w.wave_load  = 1'b1;
      STEP_PIX:   w.pix_load   = 1'b1;
      STEP_OUT: begin
        w.out_load = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target   = STEP_OUT;
      end
      STEP_NEXT: begin
        w.led_adv = 1'b1;
        w.cond    = COND_MORE;
        w.target  = STEP_PHASE;
      end
    endcase
    return w;
  endfunction

  // button that feeds each chain position
  function automatic logic [LED_W-1:0] btn_of_led(logic [LED_W-1:0] led);
    logic [LED_W-1:0] b;
    unique case (led)
      4'd0:    b = 4'd1;
      4'd1:    b = 4'd3;
      4'd2:    b = 4'd5;
      4'd3:    b = 4'd7;
      4'd4:    b = 4'd8;
      4'd5:    b = 4'd6;
      4'd6:    b = 4'd4;
      4'd7:    b = 4'd2;
      4'd8:    b = 4'd0;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic rgb_t colour_of(logic [LED_W-1:0] btn);
    rgb_t c;
    unique case (btn)
      4'd0:    c = '{r: 8'd255, g: 8'd255, b: 8'd255};
      4'd1:    c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      4'd2:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      4'd3:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      4'd4:    c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      4'd5:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      4'd6:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      4'd7:    c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      4'd8:    c = '{r: 8'd255, g: 8'd255, b: 8'd255};
      default: c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
    endcase
    return c;
  endfunction

  // floor(x / 255), exact for any product of two bytes (x <= 65025)
  function automatic logic [LEVEL_W-1:0] div255(logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

  // quarter-wave sine, Q28 Taylor series to x^13, rounded to 0..32768
  function automatic logic [15:0] quarter_sine(int f, int addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    longint      sum;
    x    = (64'd421657428 * 64'(f)) >> (addr_bits - 2);
    x2   = (x * x) >> 28;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 28) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 28) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 28) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 28) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 28) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 28) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    s = (64'(sum) + 64'd4096) >> 13;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[15:0];
  endfunction

  // full-turn breath table entry: 32768 +/- sine by half-turn
  function automatic logic [WAVE_W-1:0] wave_entry(int k, int addr_bits);
    int          half;
    int          quarter;
    int          kk;
    int          f;
    logic        neg;
    logic [15:0] q;
    half    = 1 << (addr_bits - 1);
    quarter = 1 << (addr_bits - 2);
    neg     = (k >= half);
    kk      = neg ? k - half : k;
    f       = (kk <= quarter) ? kk : half - kk;
    q       = quarter_sine(f, addr_bits);
    return neg ? 17'd32768 - {1'b0, q} : 17'd32768 + {1'b0, q};
  endfunction

endpackage

`default_nettype wire

/* hdl/rlfb_if.sv */
// Stream channels of the LED fader: tick input and pixel output.
// Depends on rlfb_pkg for field widths.
`default_nettype none

interface rlfb_tick_if;
  logic                          valid;
  logic                          ready;
  logic [rlfb_pkg::BTN_W-1:0]    pressed;
  logic [rlfb_pkg::FRAME_W-1:0]  frame_count;

  modport source (output valid, output pressed, output frame_count, input ready);
  modport sink   (input valid, input pressed, input frame_count, output ready);
endinterface

interface rlfb_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [rlfb_pkg::LED_W-1:0]    led_index;
  logic [rlfb_pkg::LEVEL_W-1:0]  red;
  logic [rlfb_pkg::LEVEL_W-1:0]  green;
  logic [rlfb_pkg::LEVEL_W-1:0]  blue;
  logic                          last;

  modport source (output valid, output led_index, output red, output green,
                  output blue, output last, input ready);
  modport sink   (input valid, input led_index, input red, input green,
                  input blue, input last, output ready);
endinterface

`default_nettype wire

/* hdl/reactive_led_fade_breathing_unit.sv */
// Reactive LED fader with idle breathing: one tick in, nine pixels out.
// Per tick: the wait step, the base step, then 9 x 6 steps (PHASE to NEXT, once per LED),
// walked by the 8-step microprogram through the one-pixel datapath; output stalls hold OUT.
// A new tick is taken only in WAIT, once the last LED's pixel is in the output register.
// Reset: LED levels cleared, idle count 1001, registers to defaults; no clearing pass.
// Depends on rlfb_pkg, rlfb_if, rlfb_wave_rom, rlfb_sequencer and rlfb_datapath.
`default_nettype none

module reactive_led_fade_breathing_unit #(
  parameter int SINE_ADDR_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  rlfb_tick_if.sink                   tick,
  rlfb_pixel_if.source                pixel,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [rlfb_pkg::CFG_W-1:0]  cfg_data
);
  import rlfb_pkg::*;

  // Microprogram, one control word per step:
  //   WAIT  - ready high; on a tick beat, presses load the LED levels and the
  //           idle counter clears or counts up (saturating just past the limit)
  //   BASE  - frame_count * phase_step, low 16 bits (one turn)
  //   PHASE - subtract button index * phase_spread for the current LED
  //   ROM   - registered read of the breath table at the phase's top bits
  //   WAVE  - table value * max_level >> 16
  //   PIX   - pick max(level, wave) when idle, scale by the button colour,
  //           decay the level by one
  //   OUT   - divide by 255 into the output register; holds while it is full and not taken
  //   NEXT  - advance the LED; back to PHASE until the last one, then WAIT
  // The output register lets the next LED's steps run while a beat waits.

  ctrl_t                  ctrl;
  stat_t                  stat;
  logic                   rom_en;
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  logic [WAVE_W-1:0]      rom_data;

  rlfb_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  rlfb_datapath #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .tick      (tick),
    .pixel     (pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rom_en    (rom_en),
    .rom_addr  (rom_addr),
    .rom_data  (rom_data)
  );

  rlfb_wave_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (rom_en),
    .addr (rom_addr),
    .data (rom_data)
  );

endmodule

`default_nettype wire

/* hdl/rlfb_wave_rom.sv */
// Breath wave ROM, one registered read per cycle.
// Contents built at elaboration by rlfb_pkg::wave_entry.
`default_nettype none

module rlfb_wave_rom #(
  parameter int ADDR_BITS = 8
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ADDR_BITS-1:0]          addr,
  output logic [rlfb_pkg::WAVE_W-1:0]   data
);
  import rlfb_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WAVE_W-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam logic [WAVE_W-1:0] ENTRY = wave_entry(k, ADDR_BITS);
    assign rom[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/rlfb_sequencer.sv */
// Step counter and control store of the LED fader microprogram.
// Depends on rlfb_pkg (step, condition and control word types).
`default_nettype none

module rlfb_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  rlfb_pkg::stat_t stat,
  output rlfb_pkg::ctrl_t ctrl
);
  import rlfb_pkg::*;

  step_t step;
  step_t step_next;
  logic  jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // next step: branch or fall through (last step wraps to the wait step)
  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_TICK:  jump = ~stat.tick_valid;
      COND_OUT_BUSY: jump = stat.out_busy;
      COND_MORE:     jump = ~stat.led_last;
    endcase
    step_next = jump ? ctrl.target : step_t'(step + 3'd1);
  end

  always_comb begin
    ctrl = program_word(step);
  end

endmodule

`default_nettype wire

/* hdl/rlfb_datapath.sv */
// Datapath of the LED fader: config registers, LED levels, idle counter,
// phase/wave/colour arithmetic and the output register. Uses rlfb_pkg.
`default_nettype none

module rlfb_datapath #(
  parameter int SINE_ADDR_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rlfb_pkg::ctrl_t               ctrl,
  output rlfb_pkg::stat_t               stat,
  rlfb_tick_if.sink                     tick,
  rlfb_pixel_if.source                  pixel,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rlfb_pkg::CFG_W-1:0]    cfg_data,
  output logic                          rom_en,
  output logic [SINE_ADDR_BITS-1:0]     rom_addr,
  input  logic [rlfb_pkg::WAVE_W-1:0]   rom_data
);
  import rlfb_pkg::*;

  logic [LEVEL_W-1:0] max_level;
  logic [IDLE_W-1:0]  idle_limit;
  logic [PHASE_W-1:0] phase_step;
  logic [PHASE_W-1:0] phase_spread;

  logic [LEVEL_W-1:0] level [LED_COUNT];
  logic [IDLE_W-1:0]  idle_count;
  logic [LED_W-1:0]   led;

  logic [PHASE_W-1:0] frame_lo;
  logic [PHASE_W-1:0] base;
  logic [PHASE_W-1:0] phase;
  logic [LEVEL_W-1:0] wave;
  logic [15:0]        prod_r;
  logic [15:0]        prod_g;
  logic [15:0]        prod_b;

  logic               out_valid;
  logic [LED_W-1:0]   out_index;
  logic [LEVEL_W-1:0] out_red;
  logic [LEVEL_W-1:0] out_green;
  logic [LEVEL_W-1:0] out_blue;
  logic               out_last;

  logic               tick_take;
  logic               out_busy;
  logic               out_take;
  logic               idle;
  logic [LED_W-1:0]   btn;
  rgb_t               colour;
  logic [31:0]        base_prod;
  logic [19:0]        spread_prod;
  logic [24:0]        wave_prod;
  logic [LEVEL_W-1:0] lvl;
  logic [LEVEL_W-1:0] pix_val;

  assign tick.ready = ctrl.tick_ready;
  assign tick_take  = ctrl.tick_ready & tick.valid;
  assign out_busy   = out_valid & ~pixel.ready;
  assign out_take   = ctrl.out_load & ~out_busy;

  assign btn         = btn_of_led(led);
  assign colour      = colour_of(btn);
  assign base_prod   = {16'd0, frame_lo} * {16'd0, phase_step};
  assign spread_prod = {16'd0, btn} * {4'd0, phase_spread};
  assign wave_prod   = {8'd0, rom_data} * {17'd0, max_level};
  assign lvl         = level[led];
  assign idle        = idle_count > idle_limit;
  assign pix_val     = (idle && (wave > lvl)) ? wave : lvl;

  assign rom_en   = ctrl.rom_load;
  assign rom_addr = phase[PHASE_W-1 -: SINE_ADDR_BITS];

  assign stat.tick_valid = tick.valid;
  assign stat.out_busy   = out_busy;
  assign stat.led_last   = (led == LED_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level    <= MAX_LEVEL_RESET;
      idle_limit   <= IDLE_LIMIT_RESET;
      phase_step   <= PHASE_STEP_RESET;
      phase_spread <= PHASE_SPREAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_LEVEL:    max_level    <= cfg_data[LEVEL_W-1:0];
        REG_IDLE_LIMIT:   idle_limit   <= cfg_data[IDLE_W-1:0];
        REG_PHASE_STEP:   phase_step   <= cfg_data[PHASE_W-1:0];
        REG_PHASE_SPREAD: phase_spread <= cfg_data[PHASE_W-1:0];
      endcase
    end
  end

  // presses land on accept; each LED decays once, after its pixel is formed
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LED_COUNT; j++) begin
        level[j] <= '0;
      end
      idle_count <= IDLE_COUNT_RESET;
    end else if (tick_take) begin
      for (int j = 0; j < LED_COUNT; j++) begin
        if (tick.pressed[btn_of_led(LED_W'(j))]) begin
          level[j] <= max_level;
        end
      end
      if (|tick.pressed) begin
        idle_count <= '0;
      end else if ((idle_count <= idle_limit) && (idle_count != IDLE_MAX)) begin
        idle_count <= idle_count + 11'd1;
      end
    end else if (ctrl.pix_load && (lvl != '0)) begin
      level[led] <= lvl - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led <= '0;
    end else if (ctrl.led_adv) begin
      led <= (led == LED_LAST) ? '0 : led + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      frame_lo <= tick.frame_count[PHASE_W-1:0];
    end
    if (ctrl.base_load) begin
      base <= base_prod[PHASE_W-1:0];
    end
    if (ctrl.phase_load) begin
      phase <= base - spread_prod[PHASE_W-1:0];
    end
    if (ctrl.wave_load) begin
      wave <= wave_prod[23:16];
    end
    if (ctrl.pix_load) begin
      prod_r <= {8'd0, colour.r} * {8'd0, pix_val};
      prod_g <= {8'd0, colour.g} * {8'd0, pix_val};
      prod_b <= {8'd0, colour.b} * {8'd0, pix_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_index <= led;
      out_red   <= div255(prod_r);
      out_green <= div255(prod_g);
      out_blue  <= div255(prod_b);
      out_last  <= (led == LED_LAST);
    end
  end

  assign pixel.valid     = out_valid;
  assign pixel.led_index = out_index;
  assign pixel.red       = out_red;
  assign pixel.green     = out_green;
  assign pixel.blue      = out_blue;
  assign pixel.last      = out_last;

endmodule

`default_nettype wire

/* hdl/rlfb_checker.sv */
// Port-level assertions for the LED fader, bound to the top level.
// Depends on rlfb_pkg for widths.
`default_nettype none

module rlfb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          tick_valid,
  input logic                          tick_ready,
  input logic                          pixel_valid,
  input logic                          pixel_ready,
  input logic [rlfb_pkg::LED_W-1:0]    pixel_led_index,
  input logic [rlfb_pkg::LEVEL_W-1:0]  pixel_red,
  input logic [rlfb_pkg::LEVEL_W-1:0]  pixel_green,
  input logic [rlfb_pkg::LEVEL_W-1:0]  pixel_blue,
  input logic                          pixel_last
);

  // a tick beat starts a frame: tick ready is low straight after the beat
  a_tick_holds_off: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick taken again straight after a tick beat");

  // mid-frame pixel pending means the frame is still in progress
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_last |-> !tick_ready)
    else $error("tick ready while a frame is still being sent");

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid)
    else $error("pixel valid dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=>
      $stable(pixel_led_index) && $stable(pixel_red) && $stable(pixel_green) &&
      $stable(pixel_blue) && $stable(pixel_last))
    else $error("pixel payload changed while stalled");

endmodule

bind reactive_led_fade_breathing_unit rlfb_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .tick_valid      (tick.valid),
  .tick_ready      (tick.ready),
  .pixel_valid     (pixel.valid),
  .pixel_ready     (pixel.ready),
  .pixel_led_index (pixel.led_index),
  .pixel_red       (pixel.red),
  .pixel_green     (pixel.green),
  .pixel_blue      (pixel.blue),
  .pixel_last      (pixel.last)
);

`default_nettype wire
